// ===== rtl/core/rm2q_pkg.sv =====
// Shared widths, constants and the queue entry type for the rotation matrix
// to quaternion core. No dependencies; every other file of the core uses it.
`default_nettype none

package rm2q_pkg;

  // Fraction bits of the Q format on all matrix and quaternion ports
  localparam int FRAC_BITS = 14;
  localparam int ONE_Q     = 1 << FRAC_BITS;

  // Branch vector parts (signed) and their magnitudes
  localparam int VW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int MW  = VW - 1;
  // Sum of four squares, square root result and remainder
  localparam int SW  = 2 * MW + 2;
  localparam int RTW = SW / 2;
  localparam int RW  = RTW + 2;
  // Rounded divide: numerator width and quotient bits
  localparam int NW  = MW + FRAC_BITS + 1;
  localparam int QB  = FRAC_BITS + 1;
  localparam int CW  = (QB > 17) ? QB : 17;

  // Identity scalar part, clamped to the output range
  localparam logic [15:0] DEG_QW = (FRAC_BITS >= 15) ? 16'd32767 : 16'(ONE_Q);

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef logic [VW-1:0] vec_t;

  typedef struct packed {
    vec_t [3:0]      v;
    logic            rpos;
    logic [SW-1:0]   sum;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/rotation_matrix_to_quaternion_core.sv =====
// Top level of the rotation matrix to quaternion core: front, queue, back.
// Depends on rm2q_pkg, rm2q_front, rm2q_queue and rm2q_back.
//
// Usage:
//   Input channel in_valid/in_ready carries one 3x3 matrix m00..m22 in
//   signed Q2.14. Output channel out_valid/out_ready carries qw, qx, qy, qz
//   in signed Q2.14 and the degenerate flag; a degenerate result is the
//   identity quaternion.
//   Throughput is one matrix per cycle while the receiver does not stall.
//   The path from the accepting edge to out_valid runs through the two front
//   stages, the queue, the square root pipeline (one root bit per stage, 19
//   stages plus its load stage), the four-lane divider (one quotient bit per
//   stage, 15 stages plus its load stage) and the output register.
//   When the receiver stalls the whole back pipeline holds; the front keeps
//   accepting until the four-entry queue and its own two stages fill, then
//   drops in_ready. Results come out in order.
//   Reset clears all valid bits and empties the queue; no data register is reset.
`default_nettype none

module rotation_matrix_to_quaternion_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [15:0]  m00,
  input  wire logic signed [15:0]  m01,
  input  wire logic signed [15:0]  m02,
  input  wire logic signed [15:0]  m10,
  input  wire logic signed [15:0]  m11,
  input  wire logic signed [15:0]  m12,
  input  wire logic signed [15:0]  m20,
  input  wire logic signed [15:0]  m21,
  input  wire logic signed [15:0]  m22,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [15:0]       qw,
  output logic signed [15:0]       qx,
  output logic signed [15:0]       qy,
  output logic signed [15:0]       qz,
  output logic                     degenerate
);

  logic              push, pop, full, empty;
  rm2q_pkg::entry_t  push_data, pop_data;

  rm2q_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .m00       (m00),
    .m01       (m01),
    .m02       (m02),
    .m10       (m10),
    .m11       (m11),
    .m12       (m12),
    .m20       (m20),
    .m21       (m21),
    .m22       (m22),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  rm2q_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  rm2q_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_data   (pop_data),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .qw         (qw),
    .qx         (qx),
    .qy         (qy),
    .qz         (qz),
    .degenerate (degenerate)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rm2q_front.sv =====
// Front part: accepts a matrix, picks the branch, forms the branch vector
// and its sum of squares. Depends on rm2q_pkg.
`default_nettype none

module rm2q_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [15:0]   m00,
  input  wire logic signed [15:0]   m01,
  input  wire logic signed [15:0]   m02,
  input  wire logic signed [15:0]   m10,
  input  wire logic signed [15:0]   m11,
  input  wire logic signed [15:0]   m12,
  input  wire logic signed [15:0]   m20,
  input  wire logic signed [15:0]   m21,
  input  wire logic signed [15:0]   m22,
  output logic                      push,
  output rm2q_pkg::entry_t          push_data,
  input  wire logic                 full
);

  logic signed [rm2q_pkg::VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [rm2q_pkg::VW-1:0] one, tr, r;
  logic signed [rm2q_pkg::VW-1:0] d21, d02, d10, s01, s02, s12;
  logic [rm2q_pkg::VW-1:0]        c_v [4];
  logic                           c_rpos;
  logic                           trace_br, x_br, y_br;

  logic                           valid1, valid2;
  logic [rm2q_pkg::VW-1:0]        v1 [4];
  logic [rm2q_pkg::VW-1:0]        v2 [4];
  logic                           rpos1, rpos2;
  logic [2*rm2q_pkg::MW-1:0]      sq2 [4];
  logic [rm2q_pkg::MW-1:0]        mag1 [4];
  logic                           en1, en2;

  // Stall chain: a stage moves when the one after it can take its request
  assign en2      = !valid2 || !full;
  assign push     = valid2 && !full;
  assign en1      = !valid1 || en2;
  assign in_ready = en1;

  // Widen the entries
  assign e00 = rm2q_pkg::VW'(m00);
  assign e01 = rm2q_pkg::VW'(m01);
  assign e02 = rm2q_pkg::VW'(m02);
  assign e10 = rm2q_pkg::VW'(m10);
  assign e11 = rm2q_pkg::VW'(m11);
  assign e12 = rm2q_pkg::VW'(m12);
  assign e20 = rm2q_pkg::VW'(m20);
  assign e21 = rm2q_pkg::VW'(m21);
  assign e22 = rm2q_pkg::VW'(m22);
  assign one = rm2q_pkg::VW'(rm2q_pkg::ONE_Q);

  assign tr  = e00 + e11 + e22;
  assign d21 = e21 - e12;
  assign d02 = e02 - e20;
  assign d10 = e10 - e01;
  assign s01 = e01 + e10;
  assign s02 = e02 + e20;
  assign s12 = e12 + e21;

  // Classify: trace branch when the trace is positive, else the largest
  // diagonal entry, ties going to the later branch
  assign trace_br = !tr[rm2q_pkg::VW-1] && (tr != '0);
  assign x_br     = (m00 > m11) && (m00 > m22);
  assign y_br     = (m11 > m22);

  always_comb begin
    if (trace_br) begin
      r      = one + tr;
      c_v[0] = r;
      c_v[1] = d21;
      c_v[2] = d02;
      c_v[3] = d10;
    end else if (x_br) begin
      r      = one + e00 - e11 - e22;
      c_v[0] = d21;
      c_v[1] = r;
      c_v[2] = s01;
      c_v[3] = s02;
    end else if (y_br) begin
      r      = one + e11 - e00 - e22;
      c_v[0] = d02;
      c_v[1] = s01;
      c_v[2] = r;
      c_v[3] = s12;
    end else begin
      r      = one + e22 - e00 - e11;
      c_v[0] = d10;
      c_v[1] = s02;
      c_v[2] = s12;
      c_v[3] = r;
    end
    c_rpos = !r[rm2q_pkg::VW-1] && (r != '0);
  end

  // Magnitudes for squaring
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag1[k] = v1[k][rm2q_pkg::VW-1] ? rm2q_pkg::MW'(-v1[k]) : rm2q_pkg::MW'(v1[k]);
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      if (en1) valid1 <= in_valid;
      if (en2) valid2 <= valid1;
    end
  end

  // Stage payloads: branch vector, then squares
  always_ff @(posedge clk) begin
    if (en1) begin
      v1    <= c_v;
      rpos1 <= c_rpos;
    end
    if (en2) begin
      v2    <= v1;
      rpos2 <= rpos1;
      for (int k = 0; k < 4; k++) begin
        sq2[k] <= mag1[k] * mag1[k];
      end
    end
  end

  // Queue request: vector, radicand sign and sum of squares
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      push_data.v[k] = v2[k];
    end
    push_data.rpos = rpos2;
    push_data.sum  = rm2q_pkg::SW'(sq2[0]) + rm2q_pkg::SW'(sq2[1])
                   + rm2q_pkg::SW'(sq2[2]) + rm2q_pkg::SW'(sq2[3]);
  end

endmodule

`default_nettype wire

// ===== rtl/core/rm2q_queue.sv =====
// Short request queue between front and back of the core.
// Depends on rm2q_pkg for the entry type and depth.
`default_nettype none

module rm2q_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  rm2q_pkg::entry_t  push_data,
  output logic              full,
  input  wire logic         pop,
  output rm2q_pkg::entry_t  pop_data,
  output logic              empty
);

  rm2q_pkg::entry_t             mem [rm2q_pkg::QDEPTH];
  logic [rm2q_pkg::QAW-1:0]     wr_ptr, rd_ptr;
  logic [rm2q_pkg::QAW:0]       count;

  assign full     = (count == (rm2q_pkg::QAW+1)'(rm2q_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Hold requests
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (rm2q_pkg::QAW+1)'(rm2q_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone push");

endmodule

`default_nettype wire

// ===== rtl/core/rm2q_back.sv =====
// Back part: pipelined square root of the sum of squares, four pipelined
// rounded dividers, saturation and the output register. Depends on rm2q_pkg.
`default_nettype none

module rm2q_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  rm2q_pkg::entry_t         pop_data,
  input  wire logic                empty,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [15:0]       qw,
  output logic signed [15:0]       qx,
  output logic signed [15:0]       qy,
  output logic signed [15:0]       qz,
  output logic                     degenerate
);

  localparam int RTW = rm2q_pkg::RTW;
  localparam int QB  = rm2q_pkg::QB;
  localparam int NW  = rm2q_pkg::NW;
  localparam int MW  = rm2q_pkg::MW;
  localparam int SW  = rm2q_pkg::SW;
  localparam int RW  = rm2q_pkg::RW;

  logic                be;
  logic                p_deg;
  logic [MW-1:0]       p_mag [4];
  logic [3:0]          p_neg;

  // Square root pipeline
  logic                sv    [RTW+1];
  logic [SW-1:0]       srad  [RTW+1];
  logic [RW-1:0]       srem  [RTW+1];
  logic [RTW-1:0]      sroot [RTW+1];
  logic [MW-1:0]       smag  [RTW+1][4];
  logic [3:0]          sneg  [RTW+1];
  logic                sdeg  [RTW+1];

  // Divider pipeline
  logic                dv    [QB+1];
  logic [RTW-1:0]      dlen  [QB+1];
  logic [NW-1:0]       drem  [QB+1][4];
  logic [QB-1:0]       dq    [QB+1][4];
  logic [3:0]          dneg  [QB+1];
  logic                ddeg  [QB+1];

  function automatic logic [15:0] sat_part(input logic neg, input logic [QB-1:0] q);
    logic [rm2q_pkg::CW-1:0] qe;
    qe = rm2q_pkg::CW'(q);
    if (neg) begin
      if (qe > rm2q_pkg::CW'(32768)) qe = rm2q_pkg::CW'(32768);
      qe = -qe;
    end else begin
      if (qe > rm2q_pkg::CW'(32767)) qe = rm2q_pkg::CW'(32767);
    end
    sat_part = qe[15:0];
  endfunction

  // Whole back pipeline moves when the output register frees up
  assign be  = !out_valid || out_ready;
  assign pop = !empty && be;

  // Decode the popped request
  always_comb begin
    p_deg = !pop_data.rpos || (pop_data.sum == '0);
    for (int k = 0; k < 4; k++) begin
      p_neg[k] = pop_data.v[k][rm2q_pkg::VW-1];
      p_mag[k] = p_neg[k] ? MW'(-pop_data.v[k]) : MW'(pop_data.v[k]);
    end
  end

  // Valid bits of every stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g <= RTW; g++) sv[g] <= 1'b0;
      for (int g = 0; g <= QB; g++) dv[g] <= 1'b0;
      out_valid <= 1'b0;
    end else if (be) begin
      sv[0] <= pop;
      for (int g = 0; g < RTW; g++) sv[g+1] <= sv[g];
      dv[0] <= sv[RTW];
      for (int g = 0; g < QB; g++) dv[g+1] <= dv[g];
      out_valid <= dv[QB];
    end
  end

  // Load the square root pipeline
  always_ff @(posedge clk) begin
    if (be) begin
      srad[0]  <= p_deg ? '0 : pop_data.sum;
      srem[0]  <= '0;
      sroot[0] <= '0;
      smag[0]  <= p_mag;
      sneg[0]  <= p_neg;
      sdeg[0]  <= p_deg;
    end
  end

  // One root bit per stage
  for (genvar g = 0; g < RTW; g++) begin : g_sqrt
    logic [RW-1:0] rem_sh, trial;

    always_comb begin
      rem_sh = {srem[g][RW-3:0], srad[g][SW-1:SW-2]};
      trial  = {sroot[g], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (be) begin
        if (rem_sh >= trial) begin
          srem[g+1]  <= rem_sh - trial;
          sroot[g+1] <= {sroot[g][RTW-2:0], 1'b1};
        end else begin
          srem[g+1]  <= rem_sh;
          sroot[g+1] <= {sroot[g][RTW-2:0], 1'b0};
        end
        srad[g+1] <= srad[g] << 2;
        smag[g+1] <= smag[g];
        sneg[g+1] <= sneg[g];
        sdeg[g+1] <= sdeg[g];
      end
    end
  end

  // Load the dividers: magnitude scaled up plus half the length for rounding
  always_ff @(posedge clk) begin
    if (be) begin
      for (int k = 0; k < 4; k++) begin
        drem[0][k] <= (NW'(smag[RTW][k]) << rm2q_pkg::FRAC_BITS) + NW'(sroot[RTW] >> 1);
        dq[0][k]   <= '0;
      end
      dlen[0] <= sroot[RTW];
      dneg[0] <= sneg[RTW];
      ddeg[0] <= sdeg[RTW];
    end
  end

  // One quotient bit per stage in each of the four lanes
  for (genvar g = 0; g < QB; g++) begin : g_div
    logic [NW-1:0] dsh;

    assign dsh = NW'(dlen[g]) << (QB - 1 - g);

    always_ff @(posedge clk) begin
      if (be) begin
        for (int k = 0; k < 4; k++) begin
          if (drem[g][k] >= dsh) begin
            drem[g+1][k] <= drem[g][k] - dsh;
            dq[g+1][k]   <= {dq[g][k][QB-2:0], 1'b1};
          end else begin
            drem[g+1][k] <= drem[g][k];
            dq[g+1][k]   <= {dq[g][k][QB-2:0], 1'b0};
          end
        end
        dlen[g+1] <= dlen[g];
        dneg[g+1] <= dneg[g];
        ddeg[g+1] <= ddeg[g];
      end
    end
  end

  // Output register: saturated parts or identity
  always_ff @(posedge clk) begin
    if (be) begin
      if (ddeg[QB]) begin
        qw         <= rm2q_pkg::DEG_QW;
        qx         <= '0;
        qy         <= '0;
        qz         <= '0;
        degenerate <= 1'b1;
      end else begin
        qw         <= sat_part(dneg[QB][0], dq[QB][0]);
        qx         <= sat_part(dneg[QB][1], dq[QB][1]);
        qy         <= sat_part(dneg[QB][2], dq[QB][2]);
        qz         <= sat_part(dneg[QB][3], dq[QB][3]);
        degenerate <= 1'b0;
      end
    end
  end

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sv[RTW] |-> srem[RTW] <= {sroot[RTW], 1'b0})
    else $error("square root remainder out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dv[QB] && !ddeg[QB] |->
      (drem[QB][0] < NW'(dlen[QB])) && (drem[QB][1] < NW'(dlen[QB])) &&
      (drem[QB][2] < NW'(dlen[QB])) && (drem[QB][3] < NW'(dlen[QB])))
    else $error("divider remainder not below length");

  a_deg_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> (qx == '0) && (qy == '0) && (qz == '0))
    else $error("degenerate result is not identity");

endmodule

`default_nettype wire

// ===== verif/tb_rotation_matrix_to_quaternion_core.sv =====
// Self-checking testbench for the rotation matrix to quaternion core.
// Depends on rm2q_pkg (FRAC_BITS) and rotation_matrix_to_quaternion_core.
// Directed table, then random matrices checked against a built-in predictor.
module tb_rotation_matrix_to_quaternion_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1550;
  localparam int LATENCY      = 39;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
    logic               deg;
  } quat_t;

  typedef struct {
    logic signed [15:0] m [9];
    logic               known;
    quat_t              q;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0;
  logic signed [15:0] m12 = '0, m20 = '0, m21 = '0, m22 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] qw, qx, qy, qz;
  logic degenerate;

  quat_t pending_quats[$];
  int    mismatches = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_cycles = 0;

  rotation_matrix_to_quaternion_core i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22), .out_valid(out_valid),
    .out_ready(out_ready), .qw(qw), .qx(qx), .qy(qy), .qz(qz),
    .degenerate(degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale one part by 1/len, round half away from zero, saturate
  function automatic logic signed [15:0] scale_part(longint v, longint unsigned len);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = ((mag << rm2q_pkg::FRAC_BITS) + (len >> 1)) / len;
    if (v < 0) begin
      if (q > 32768) q = 32768;
      return 16'(-longint'(q));
    end
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  // Shepperd branch vector, normalized
  function automatic quat_t quat_of_matrix(logic signed [15:0] m [9]);
    longint a [9];
    longint v [4];
    longint r, tr, one;
    longint unsigned sum, len, mg;
    quat_t q;
    one = longint'(1) << rm2q_pkg::FRAC_BITS;
    for (int i = 0; i < 9; i++) a[i] = m[i];
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      r = one + tr;
      v = '{r, a[7] - a[5], a[2] - a[6], a[3] - a[1]};
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      r = one + a[0] - a[4] - a[8];
      v = '{a[7] - a[5], r, a[1] + a[3], a[2] + a[6]};
    end else if (a[4] > a[8]) begin
      r = one + a[4] - a[0] - a[8];
      v = '{a[2] - a[6], a[1] + a[3], r, a[5] + a[7]};
    end else begin
      r = one + a[8] - a[0] - a[4];
      v = '{a[3] - a[1], a[2] + a[6], a[5] + a[7], r};
    end
    len = 0;
    if (r > 0) begin
      sum = 0;
      for (int i = 0; i < 4; i++) begin
        mg = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
        sum += mg * mg;
      end
      len = root_floor(sum);
    end
    if (len == 0) begin
      q.w = (one > 32767) ? 16'sd32767 : 16'(one);
      q.x = '0; q.y = '0; q.z = '0; q.deg = 1'b1;
      return q;
    end
    q.w = scale_part(v[0], len);
    q.x = scale_part(v[1], len);
    q.y = scale_part(v[2], len);
    q.z = scale_part(v[3], len);
    q.deg = 1'b0;
    return q;
  endfunction

  // Offer one matrix and hold it until accepted; drop valid only while idling
  task automatic send_matrix(logic signed [15:0] m [9], bit known, quat_t qk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
      {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_quats.push_back(known ? qk : quat_of_matrix(m));
  endtask

  // Random rotation-like or raw matrix
  function automatic void rand_matrix(output logic signed [15:0] m [9]);
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      if (kind < 3) m[i] = 16'($urandom);
      else if (kind < 8) m[i] = 16'($signed($urandom_range(32768)) - 16384);
      else m[i] = 16'($signed($urandom_range(64)) - 32);
    end
    if (kind == 8) m[$urandom_range(8)] = 16'sd16384;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls plus a long hold-off window
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    out_ready <= !rst && hold_cycles <= 1 &&
                 ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    quat_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{qw, qx, qy, qz, degenerate};
      if (pending_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected quaternion %p", got);
      end else begin
        want = pending_quats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    row_t dir_rows [$];
    row_t rw;
    logic signed [15:0] m [9];
    quat_t ident, zq;
    ident = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0};
    zq    = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0};
    // Directed table: identity, all-extremes, each branch, ties
    rw.known = 1; rw.q = ident;
    rw.m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; dir_rows.push_back(rw);
    rw.q = zq;
    rw.m = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}; dir_rows.push_back(rw);
    rw.m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; dir_rows.push_back(rw);
    rw.known = 0;
    rw.m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    dir_rows.push_back(rw);
    rw.m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    dir_rows.push_back(rw);
    rw.m = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
    dir_rows.push_back(rw);
    rw.m = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
    dir_rows.push_back(rw);
    rw.m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; dir_rows.push_back(rw);
    rw.m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; dir_rows.push_back(rw);
    rw.m = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}; dir_rows.push_back(rw);
    rw.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; dir_rows.push_back(rw);
    rw.m = '{-100, 5, 7, 9, -100, 3, 1, 2, -100}; dir_rows.push_back(rw);
    rw.m = '{-50, 5, 7, 9, -50, 3, 1, 2, -200}; dir_rows.push_back(rw);
    rw.m = '{-200, 5, 7, 9, -50, 3, 1, 2, -200}; dir_rows.push_back(rw);
    rw.m = '{8192, -14189, 0, 14189, 8192, 0, 0, 0, 16384}; dir_rows.push_back(rw);
    rw.m = '{1, 2, 3, 4, 5, 6, 7, 8, -14}; dir_rows.push_back(rw);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) send_matrix(dir_rows[i].m, dir_rows[i].known, dir_rows[i].q);
    drain();
    // Random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 10 : 69) : 0;
      recv_stall_pct = (ph == 2) ? 69 : ((ph == 3) ? 10 : 0);
      if (ph == 0) hold_cycles <= 200;
      for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
        rand_matrix(m);
        send_matrix(m, 1'b0, ident);
        if (k % 150 == 149) begin
          in_valid <= 1'b0;
          repeat (1 + $urandom_range(3)) @(posedge clk);
        end
      end
      drain();
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && pending_quats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
